@@ rtl/scrf_pkg.sv @@
package scrf_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned EPOCH_W = 4;

  // Largest map that the 10-bit source column can address.
  localparam int unsigned MAX_MAP_DEPTH = 1 << COL_W;

  localparam int unsigned     SRC_COLS_DEF  = 1024;
  localparam logic [31:0]     COUNT_MAX_DEF = 32'd65535;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_SET     = 2'd1,
    OP_COLUMN  = 2'd2,
    OP_ROW_END = 2'd3
  } op_e;

  localparam logic KIND_COLUMN  = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  // One map entry: it counts as mapped only if valid is set and the epoch
  // tag matches the epoch that was current when the lookup was issued.
  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] epoch;
    logic [COL_W-1:0]   col;
  } map_entry_t;

  // Lookup stage handed from the map controller to the count unit.
  typedef struct packed {
    logic               valid;
    op_e                op;
    logic               in_range;
    logic [EPOCH_W-1:0] epoch;
  } lookup_t;

endpackage

@@ rtl/scrf_if.sv @@
interface scrf_in_if;
  logic                          valid;
  logic                          ready;
  logic [scrf_pkg::OP_W-1:0]     operation;
  logic [scrf_pkg::COL_W-1:0]    src_col;
  logic [scrf_pkg::COL_W-1:0]    out_col;

  modport source (output valid, output operation, output src_col, output out_col,
                  input ready);
  modport sink (input valid, input operation, input src_col, input out_col,
                output ready);
endinterface

interface scrf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [scrf_pkg::VALUE_W-1:0]  value;
  logic                          overflow;

  modport source (output valid, output result_kind, output value, output overflow,
                  input ready);
  modport sink (input valid, input result_kind, input value, input overflow,
                output ready);
endinterface

@@ rtl/scrf_ram.sv @@
module scrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/scrf_map_ctrl.sv @@
module scrf_map_ctrl #(
  parameter int unsigned SRC_COLS = scrf_pkg::SRC_COLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  scrf_in_if.sink             in_i,
  input  logic                advance_i,
  output scrf_pkg::lookup_t   lookup_o,
  output scrf_pkg::map_entry_t entry_o
);
  import scrf_pkg::*;

  localparam int unsigned MapDepth = (SRC_COLS > MAX_MAP_DEPTH) ? MAX_MAP_DEPTH : SRC_COLS;
  localparam int unsigned AddrW    = $clog2(MapDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MapDepth - 1);

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   sweep_q, sweep_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               s1_valid_q, s1_valid_d;
  lookup_t            s1_q;

  logic               accept;
  op_e                op;
  logic               in_range;
  logic [AddrW-1:0]   addr;
  logic [EPOCH_W-1:0] epoch_inc;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  map_entry_t         ram_wdata;
  logic               ram_re;
  logic [$bits(map_entry_t)-1:0] ram_rdata;

  assign op        = op_e'(in_i.operation);
  assign in_range  = 32'(in_i.src_col) < 32'(SRC_COLS);
  assign addr      = in_i.src_col[AddrW-1:0];
  assign epoch_inc = epoch_q + EPOCH_W'(1);

  // A new item enters only when the lookup stage is empty or moving on.
  assign in_i.ready = (state_q == ST_RUN) && (!s1_valid_q || advance_i);
  assign accept     = in_i.valid && in_i.ready;

  // Set entries write at acceptance, so a lookup accepted in the next cycle
  // already reads the new value through the registered read port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '{valid: 1'b1, epoch: epoch_q, col: in_i.out_col};
    if (state_q == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else if (accept && (op == OP_SET) && in_range) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = accept && (op == OP_COLUMN);

  scrf_ram #(
    .WIDTH ($bits(map_entry_t)),
    .DEPTH (MapDepth)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // A clear only advances the epoch. When the epoch wraps, old tags could
  // match again, so the whole map is swept invalid first.
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    epoch_d = epoch_q;
    case (state_q)
      ST_SWEEP: begin
        sweep_d = sweep_q + AddrW'(1);
        if (sweep_q == LastAddr) begin
          state_d = ST_RUN;
          sweep_d = '0;
        end
      end
      ST_RUN: begin
        if (accept && (op == OP_CLEAR)) begin
          epoch_d = epoch_inc;
          if (epoch_inc == '0) begin
            state_d = ST_SWEEP;
            sweep_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_SWEEP;
        sweep_d = '0;
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      sweep_q    <= '0;
      epoch_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      epoch_q    <= epoch_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.valid    <= 1'b1;
      s1_q.op       <= op;
      s1_q.in_range <= in_range;
      s1_q.epoch    <= epoch_q;
    end
  end

  always_comb begin
    lookup_o       = s1_q;
    lookup_o.valid = s1_valid_q;
  end

  assign entry_o = map_entry_t'(ram_rdata);

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !in_i.ready
  ) else $error("item accepted during map sweep");

  a_wrap_sweeps: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_CLEAR) && (epoch_q == '1)) |=> (state_q == ST_SWEEP)
  ) else $error("epoch wrapped without a map sweep");

  a_stage_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance_i) |=> (s1_valid_q && $stable(s1_q))
  ) else $error("stalled lookup stage changed");
`endif

endmodule

@@ rtl/scrf_count.sv @@
module scrf_count #(
  parameter logic [31:0] COUNT_MAX = scrf_pkg::COUNT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scrf_pkg::lookup_t    lookup_i,
  input  scrf_pkg::map_entry_t entry_i,
  output logic                 advance_o,
  scrf_out_if.source           out_o
);
  import scrf_pkg::*;

  localparam logic [VALUE_W-1:0] CountLimit =
      (COUNT_MAX > 32'(VALUE_MAX)) ? VALUE_MAX : COUNT_MAX[VALUE_W-1:0];

  logic [VALUE_W-1:0] count_q, count_d;
  logic               sat_q, sat_d;
  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               ovf_q, ovf_d;
  logic               fire;
  logic               hit;
  logic               emit;

  // The output register frees up in the cycle its item is taken.
  assign advance_o = !out_valid_q || out_o.ready;
  assign fire      = lookup_i.valid && advance_o;
  assign hit       = lookup_i.in_range && entry_i.valid && (entry_i.epoch == lookup_i.epoch);

  always_comb begin
    count_d = count_q;
    sat_d   = sat_q;
    emit    = 1'b0;
    kind_d  = kind_q;
    value_d = value_q;
    ovf_d   = ovf_q;
    if (fire) begin
      case (lookup_i.op)
        OP_CLEAR: begin
          count_d = '0;
          sat_d   = 1'b0;
        end
        OP_SET: begin
        end
        OP_COLUMN: begin
          if (hit) begin
            if (count_q >= CountLimit) begin
              count_d = CountLimit;
              sat_d   = 1'b1;
            end else begin
              count_d = count_q + VALUE_W'(1);
            end
            emit    = 1'b1;
            kind_d  = KIND_COLUMN;
            value_d = VALUE_W'(entry_i.col);
            ovf_d   = sat_d;
          end
        end
        OP_ROW_END: begin
          emit    = 1'b1;
          kind_d  = KIND_ROW_END;
          value_d = count_q;
          ovf_d   = sat_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.value       = value_q;
  assign out_o.overflow    = ovf_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountLimit
  ) else $error("nonzero count above its limit");

  a_sat_at_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (count_q == CountLimit)
  ) else $error("overflow flag set below the limit");

  a_clear_zeroes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (fire && (lookup_i.op == OP_CLEAR)) |=> ((count_q == '0) && !sat_q)
  ) else $error("clear did not reset count and flag");
`endif

endmodule

@@ rtl/sparse_column_remap_filter.sv @@
// Column filter for compressed-row submatrix extraction. Clear, set-map,
// column and row-end items are accepted at one per cycle while no sweep
// runs and the output is not held. A column hit or row-end result goes
// from the registered map read into the output register; while it waits,
// one more item can enter the lookup stage and is held there. The map is
// a single-port-write, registered-read RAM of min(SRC_COLS, 1024) entries
// tagged with a 4-bit epoch, so a clear only advances the epoch; after
// reset and on every sixteenth clear the block first sweeps the map
// invalid and accepts no item meanwhile. The nonzero count saturates at
// min(COUNT_MAX, 65535) and sets the overflow flag until the next clear.
module sparse_column_remap_filter #(
  parameter int unsigned SRC_COLS  = scrf_pkg::SRC_COLS_DEF,
  parameter logic [31:0] COUNT_MAX = scrf_pkg::COUNT_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scrf_in_if.sink    in_i,
  scrf_out_if.source out_o
);
  import scrf_pkg::*;

  lookup_t    lookup;
  map_entry_t entry;
  logic       advance;

  scrf_map_ctrl #(
    .SRC_COLS (SRC_COLS)
  ) u_map_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .lookup_o  (lookup),
    .entry_o   (entry)
  );

  scrf_count #(
    .COUNT_MAX (COUNT_MAX)
  ) u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lookup_i  (lookup),
    .entry_i   (entry),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule
